### rtl/fmcd_pkg.sv
// ----------------------------------------------------------------------------
// fmcd_pkg
// Shared types and constants for the debounced fan mode controller.
// ----------------------------------------------------------------------------
package fmcd_pkg;

  localparam int unsigned NumKeys   = 4;
  localparam int unsigned TempW     = 12;
  localparam int unsigned DutyW     = 12;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW  = 12;

  localparam logic signed [TempW-1:0] HighThresholdReset = 12'sd300;
  localparam logic signed [TempW-1:0] LowThresholdReset  = 12'sd250;
  localparam logic [DutyW-1:0]        HighDutyReset      = 12'd1500;
  localparam logic [DutyW-1:0]        LowDutyReset       = 12'd500;

  // key order inside the level and press vectors
  localparam int unsigned KeyPower = 0;
  localparam int unsigned KeyMode  = 1;
  localparam int unsigned KeySpeed = 2;
  localparam int unsigned KeySweep = 3;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_HIGH_THRESHOLD = 8'd0,
    CFG_LOW_THRESHOLD  = 8'd1,
    CFG_HIGH_DUTY      = 8'd2,
    CFG_LOW_DUTY       = 8'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    SPEED_HIGH    = 2'd0,
    SPEED_LOW     = 2'd1,
    SPEED_STOPPED = 2'd2
  } speed_t;

  typedef struct packed {
    logic signed [TempW-1:0] high_threshold;
    logic signed [TempW-1:0] low_threshold;
    logic [DutyW-1:0]        high_duty;
    logic [DutyW-1:0]        low_duty;
  } cfg_t;

  typedef struct packed {
    logic             sweep_on;
    logic [1:0]       manual_speed;
    logic [1:0]       fan_mode;
    logic [DutyW-1:0] fan_duty;
  } result_t;

endpackage

### rtl/fan_mode_controller_debounced_core.sv
// ----------------------------------------------------------------------------
// fan_mode_controller_debounced_core
// Scan-tick fan controller with qualified keys and temperature-driven duty.
// ----------------------------------------------------------------------------
// One scan tick is taken per request on the slave side, one per clock cycle
// when the master side keeps up. A tick passes an input register and leaves
// from the result register; key, mode, speed and sweep state
// update as the tick moves from the input register to the result register, so
// each tick sees the state left by the one before it. A tick whose temp_valid
// flag is low is taken and dropped without a result. The configuration
// channel is always ready and takes one register write per cycle.
module fan_mode_controller_debounced_core (
  input  logic                              clk,
  input  logic                              rst,
  // tdata: power_key, mode_key, speed_key, sweep_key, temperature[11:0]
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,
  // tuser: temp_valid
  input  logic [0:0]                        s_tuser,
  // tdata: fan_duty[11:0], fan_mode[1:0], manual_speed[1:0], sweep_on, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fmcd_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [fmcd_pkg::CfgDataW-1:0]     cfg_data
);
  import fmcd_pkg::*;

  localparam int unsigned ResultW = $bits(result_t);

  cfg_t                    cfg;
  logic                    in_valid;
  logic [NumKeys-1:0]      in_keys;
  logic signed [TempW-1:0] in_temp;
  logic                    advance;
  logic [NumKeys-1:0]      press;
  result_t                 result_next;
  result_t                 result;

  assign cfg_ready = 1'b1;

  fmcd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance the input register into the result register
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid & s_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      in_keys <= s_tdata[NumKeys-1:0];
      in_temp <= $signed(s_tdata[NumKeys +: TempW]);
    end
  end

  fmcd_key_qual u_key_qual (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .level (in_keys),
    .press (press)
  );

  fmcd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .press       (press),
    .temperature (in_temp),
    .cfg         (cfg),
    .result      (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tdata = {{(24 - ResultW){1'b0}}, result};

`ifndef ASSERT_OFF
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.fan_mode == MODE_STOP) |->
      (result.fan_duty == '0 && !result.sweep_on))
    else $error("stop result with nonzero duty or sweep");

  a_auto_sweep: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && result.fan_mode == MODE_AUTO) |-> result.sweep_on)
    else $error("auto result without sweep");

  a_valid_tick_loads: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0]) |=> in_valid)
    else $error("valid tick not held in input register");

  a_invalid_tick_drops: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser[0]) |=> !in_valid)
    else $error("invalid tick entered the input register");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("advanced tick did not reach the result register");
`endif

endmodule

### rtl/fmcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// fmcd_cfg_regs
// Threshold and duty registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module fmcd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [fmcd_pkg::CfgIndexW-1:0] wr_index,
  input  logic [fmcd_pkg::CfgDataW-1:0]  wr_data,
  output fmcd_pkg::cfg_t                cfg
);
  import fmcd_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.high_threshold <= HighThresholdReset;
      regs.low_threshold  <= LowThresholdReset;
      regs.high_duty      <= HighDutyReset;
      regs.low_duty       <= LowDutyReset;
    end else if (wr_en) begin
      case (wr_index)
        CFG_HIGH_THRESHOLD: regs.high_threshold <= $signed(wr_data[TempW-1:0]);
        CFG_LOW_THRESHOLD:  regs.low_threshold  <= $signed(wr_data[TempW-1:0]);
        CFG_HIGH_DUTY:      regs.high_duty      <= wr_data[DutyW-1:0];
        CFG_LOW_DUTY:       regs.low_duty       <= wr_data[DutyW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

### rtl/fmcd_key_qual.sv
// ----------------------------------------------------------------------------
// fmcd_key_qual
// Per-key press qualifier: low, low again, then high gives one press.
// ----------------------------------------------------------------------------
module fmcd_key_qual (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [fmcd_pkg::NumKeys-1:0]  level,
  output logic [fmcd_pkg::NumKeys-1:0]  press
);
  import fmcd_pkg::*;

  typedef enum logic [1:0] {
    Q_IDLE     = 2'd0,
    Q_SAW_LOW  = 2'd1,
    Q_SAW_LOW2 = 2'd2
  } qual_t;

  qual_t qual [NumKeys];
  qual_t qual_next [NumKeys];

  always_comb begin
    for (int k = 0; k < NumKeys; k++) begin
      press[k] = 1'b0;
      case (qual[k])
        Q_SAW_LOW: begin
          qual_next[k] = level[k] ? Q_IDLE : Q_SAW_LOW2;
        end
        Q_SAW_LOW2: begin
          press[k]     = level[k];
          qual_next[k] = Q_IDLE;
        end
        default: begin
          qual_next[k] = level[k] ? Q_IDLE : Q_SAW_LOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumKeys; k++) qual[k] <= Q_IDLE;
    end else if (en) begin
      for (int k = 0; k < NumKeys; k++) qual[k] <= qual_next[k];
    end
  end

endmodule

### rtl/fmcd_ctrl.sv
// ----------------------------------------------------------------------------
// fmcd_ctrl
// Mode, speed and sweep state; applies press events and works out the duty.
// ----------------------------------------------------------------------------
module fmcd_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [fmcd_pkg::NumKeys-1:0]        press,
  input  logic signed [fmcd_pkg::TempW-1:0]   temperature,
  input  fmcd_pkg::cfg_t                      cfg,
  output fmcd_pkg::result_t                   result
);
  import fmcd_pkg::*;

  mode_t            mode, mode_next;
  speed_t           speed, speed_next;
  logic             sweep, sweep_next;
  logic [DutyW-1:0] duty;

  always_comb begin
    mode_next  = mode;
    speed_next = speed;
    sweep_next = sweep;
    duty       = '0;

    if (press[KeyPower]) begin
      mode_next = (mode_next != MODE_STOP) ? MODE_STOP : MODE_AUTO;
    end
    if (press[KeyMode]) begin
      if (mode_next == MODE_AUTO) begin
        mode_next  = MODE_MANUAL;
        speed_next = SPEED_STOPPED;
      end else begin
        mode_next = MODE_AUTO;
      end
    end
    if (press[KeySpeed]) begin
      case (speed_next)
        SPEED_HIGH: speed_next = SPEED_LOW;
        SPEED_LOW:  speed_next = SPEED_STOPPED;
        default:    speed_next = SPEED_HIGH;
      endcase
    end
    if (press[KeySweep]) begin
      sweep_next = ~sweep_next;
    end

    case (mode_next)
      MODE_STOP: begin
        sweep_next = 1'b0;
      end
      MODE_MANUAL: begin
        case (speed_next)
          SPEED_HIGH: duty = cfg.high_duty;
          SPEED_LOW:  duty = cfg.low_duty;
          default:    duty = '0;
        endcase
      end
      MODE_AUTO: begin
        sweep_next = 1'b1;
        if (temperature > cfg.high_threshold) begin
          duty = cfg.high_duty;
        end else if (temperature > cfg.low_threshold) begin
          duty = cfg.low_duty;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_AUTO;
      speed <= SPEED_STOPPED;
      sweep <= 1'b0;
    end else if (en) begin
      mode  <= mode_next;
      speed <= speed_next;
      sweep <= sweep_next;
    end
  end

  assign result.fan_duty     = duty;
  assign result.fan_mode     = mode_next;
  assign result.manual_speed = speed_next;
  assign result.sweep_on     = sweep_next;

endmodule

### tb/sv/fan_mode_controller_debounced_core_tb.sv
// ----------------------------------------------------------------------------
// fan_mode_controller_debounced_core_tb
// Self-checking bench for the debounced fan mode controller. Scan ticks go in
// through the slave stream in bursts and the results leave through the master
// stream under a stall pattern. Every result is compared against a typed value
// or an in-bench model of the key qualifiers, the mode, speed and sweep state
// and the duty selection. The run opens with a short table of directed ticks,
// then walks several threshold and duty settings with random key press sequences.
// ----------------------------------------------------------------------------
module fan_mode_controller_debounced_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmcd_pkg::*;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned ReportLimit  = 10;
  localparam int unsigned PhaseTicks   = 140;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned DirectedRows = 25;
  localparam int unsigned HoldCycles   = 400;

  typedef enum logic [1:0] {
    QUAL_IDLE          = 2'd0,
    QUAL_SAW_LOW       = 2'd1,
    QUAL_SAW_LOW_TWICE = 2'd2
  } qual_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_FIRST_LOW,
    GEN_SECOND_LOW,
    GEN_RELEASE
  } key_gen_t;

  typedef struct {
    logic [3:0]              keys;
    logic signed [TempW-1:0] temp;
    logic                    valid;
    logic                    typed;
    result_t                 want;
  } tick_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;
  logic [0:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  // model state
  qual_t                   key_qual [NumKeys] = '{default: QUAL_IDLE};
  mode_t                   mode_m  = MODE_AUTO;
  speed_t                  speed_m = SPEED_STOPPED;
  logic                    sweep_m = 1'b0;
  logic signed [TempW-1:0] hi_thr_m  = HighThresholdReset;
  logic signed [TempW-1:0] lo_thr_m  = LowThresholdReset;
  logic [DutyW-1:0]        hi_duty_m = HighDutyReset;
  logic [DutyW-1:0]        lo_duty_m = LowDutyReset;

  result_t     pending_results [$];
  tick_row_t   directed_ticks [DirectedRows];
  key_gen_t    key_gen [NumKeys] = '{default: GEN_IDLE};

  int unsigned ticks_sent, ticks_skipped, results_checked, reg_writes, settings_run;
  int unsigned mismatches, burst_left, gap_max, quiet_cycles;
  int unsigned hold_left, pattern_age;
  bit          hold_done;
  logic [15:0] stall_mask = 16'hFFFF;

  fan_mode_controller_debounced_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic result_t fan_step(input logic [3:0] keys,
                                       input logic signed [TempW-1:0] temp);
    logic [3:0] press;
    result_t    r;
    press = '0;
    r = '0;
    for (int k = 0; k < NumKeys; k++) begin
      case (key_qual[k])
        QUAL_SAW_LOW: key_qual[k] = keys[k] ? QUAL_IDLE : QUAL_SAW_LOW_TWICE;
        QUAL_SAW_LOW_TWICE: begin
          press[k] = keys[k];
          key_qual[k] = QUAL_IDLE;
        end
        default: key_qual[k] = keys[k] ? QUAL_IDLE : QUAL_SAW_LOW;
      endcase
    end
    if (press[KeyPower]) mode_m = (mode_m != MODE_STOP) ? MODE_STOP : MODE_AUTO;
    if (press[KeyMode]) begin
      if (mode_m == MODE_AUTO) begin
        mode_m = MODE_MANUAL;
        speed_m = SPEED_STOPPED;
      end else begin
        mode_m = MODE_AUTO;
      end
    end
    if (press[KeySpeed]) begin
      case (speed_m)
        SPEED_HIGH: speed_m = SPEED_LOW;
        SPEED_LOW:  speed_m = SPEED_STOPPED;
        default:    speed_m = SPEED_HIGH;
      endcase
    end
    if (press[KeySweep]) sweep_m = ~sweep_m;
    case (mode_m)
      MODE_STOP: sweep_m = 1'b0;
      MODE_MANUAL: begin
        if (speed_m == SPEED_HIGH) r.fan_duty = hi_duty_m;
        else if (speed_m == SPEED_LOW) r.fan_duty = lo_duty_m;
      end
      MODE_AUTO: begin
        sweep_m = 1'b1;
        if ($signed(temp) > $signed(hi_thr_m)) r.fan_duty = hi_duty_m;
        else if ($signed(temp) > $signed(lo_thr_m)) r.fan_duty = lo_duty_m;
      end
      default: ;
    endcase
    r.fan_mode = mode_m;
    r.manual_speed = speed_m;
    r.sweep_on = sweep_m;
    return r;
  endfunction

  // offer one tick and hold it until the request is taken
  task automatic offer_tick(input logic [3:0] keys, input logic signed [TempW-1:0] temp,
                            input logic valid, input logic typed, input result_t want);
    result_t r;
    s_tvalid <= 1'b1;
    s_tdata <= {temp, keys};
    s_tuser <= valid;
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
    if (valid) begin
      r = fan_step(keys, temp);
      pending_results.push_back(typed ? want : r);
    end else begin
      ticks_skipped++;
    end
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_HIGH_THRESHOLD: hi_thr_m = data;
      CFG_LOW_THRESHOLD:  lo_thr_m = data;
      CFG_HIGH_DUTY:      hi_duty_m = data;
      CFG_LOW_DUTY:       lo_duty_m = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int hi_thr, input int lo_thr,
                               input int hi_duty, input int lo_duty);
    write_reg(CfgIndexW'($urandom_range(NumKeys, 255)), CfgDataW'($urandom));
    write_reg(CFG_HIGH_THRESHOLD, CfgDataW'(hi_thr));
    write_reg(CFG_LOW_THRESHOLD, CfgDataW'(lo_thr));
    write_reg(CFG_HIGH_DUTY, CfgDataW'(hi_duty));
    write_reg(CFG_LOW_DUTY, CfgDataW'(lo_duty));
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // mostly clean press sequences, some broken ones and stray levels
  task automatic next_keys(output logic [3:0] lv);
    for (int k = 0; k < NumKeys; k++) begin
      case (key_gen[k])
        GEN_IDLE: begin
          if ($urandom_range(0, 3) == 0) begin
            lv[k] = 1'b0;
            key_gen[k] = GEN_FIRST_LOW;
          end else begin
            lv[k] = ($urandom_range(0, 7) != 0);
          end
        end
        GEN_FIRST_LOW: begin
          lv[k] = 1'b0;
          key_gen[k] = GEN_SECOND_LOW;
        end
        GEN_SECOND_LOW: begin
          lv[k] = ($urandom_range(0, 7) != 0);
          key_gen[k] = lv[k] ? GEN_RELEASE : GEN_IDLE;
        end
        default: begin
          lv[k] = ($urandom_range(0, 7) != 0);
          key_gen[k] = GEN_IDLE;
        end
      endcase
    end
  endtask

  function automatic logic [TempW-1:0] pick_temp();
    int unsigned sel;
    int          t;
    sel = $urandom_range(0, 19);
    if (sel == 0) t = int'($urandom_range(0, 4095));
    else if (sel < 4) t = int'(hi_thr_m) + int'($urandom_range(0, 4)) - 2;
    else if (sel < 7) t = int'(lo_thr_m) + int'($urandom_range(0, 4)) - 2;
    else t = int'($urandom_range(0, 1650)) - 400;
    return TempW'(t);
  endfunction

  task automatic check_result(input logic [23:0] got);
    result_t want;
    logic    bad;
    results_checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("result %0d: unexpected data %h with nothing outstanding",
                 results_checked, got);
      return;
    end
    want = pending_results.pop_front();
    bad = (got[11:0] != want.fan_duty) || (got[13:12] != want.fan_mode) ||
          (got[15:14] != want.manual_speed) || (got[16] != want.sweep_on) ||
          (got[23:17] != '0);
    if (bad) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("result %0d: expected duty %0d mode %0d speed %0d sweep %0d",
                 results_checked, want.fan_duty, want.fan_mode, want.manual_speed,
                 want.sweep_on);
        $display("result %0d: got duty %0d mode %0d speed %0d sweep %0d pad %h",
                 results_checked, got[11:0], got[13:12], got[15:14], got[16],
                 got[23:17]);
      end
    end
  endtask

  // receiver: check, then stall on a pattern, with one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_checked >= 300 && s_tvalid) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_tready <= 1'b0;
      end else begin
        pattern_age++;
        if (pattern_age == 64) begin
          pattern_age = 0;
          stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
        end
        m_tready <= stall_mask[pattern_age % 16];
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
               QuietLimit, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [3:0]              keys;
    logic signed [TempW-1:0] temp;
    logic                    valid;
    directed_ticks = '{
      '{4'hF, 12'sd0,     1'b1, 1'b1, '{1'b1, SPEED_STOPPED, MODE_AUTO, 12'd0}},
      '{4'hF, 12'sd1250,  1'b1, 1'b1, '{1'b1, SPEED_STOPPED, MODE_AUTO, 12'd1500}},
      '{4'hF, -12'sd400,  1'b1, 1'b1, '{1'b1, SPEED_STOPPED, MODE_AUTO, 12'd0}},
      '{4'hF, 12'sd300,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd251,   1'b1, 1'b0, '0},
      '{4'h0, 12'sd2047,  1'b0, 1'b0, '0},
      '{4'hE, 12'sd100,   1'b1, 1'b0, '0},
      '{4'hE, 12'sd100,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd100,   1'b1, 1'b0, '0},
      '{4'hE, 12'sd100,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd100,   1'b0, 1'b0, '0},
      '{4'hE, 12'sd100,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hD, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hD, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hB, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hB, 12'sd400,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd400,   1'b1, 1'b0, '0},
      '{4'h7, 12'sd260,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd260,   1'b1, 1'b0, '0},
      '{4'h0, 12'sd260,   1'b1, 1'b0, '0},
      '{4'h0, 12'sd260,   1'b1, 1'b0, '0},
      '{4'hF, 12'sd2047,  1'b1, 1'b0, '0},
      '{4'hF, -12'sd2048, 1'b1, 1'b0, '0}
    };
    gap_max = 6;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_ticks[i]) begin
      pace();
      offer_tick(directed_ticks[i].keys, directed_ticks[i].temp, directed_ticks[i].valid,
                 directed_ticks[i].typed, directed_ticks[i].want);
    end
    drain();

    for (int p = 1; p <= NumPhases; p++) begin
      case (p)
        1: apply_setting(1250, -400, 4095, 0);
        2: apply_setting(-400, 1250, 0, 4095);
        3: apply_setting(HighThresholdReset, LowThresholdReset, HighDutyReset, LowDutyReset);
        default: apply_setting(int'($urandom_range(0, 1650)) - 400,
                               int'($urandom_range(0, 1650)) - 400,
                               $urandom_range(0, 4095), $urandom_range(0, 4095));
      endcase
      gap_max = (p % 3 == 0) ? 0 : 6;
      burst_left = 0;
      for (int n = 0; n < PhaseTicks; n++) begin
        next_keys(keys);
        valid = ($urandom_range(0, 7) != 0);
        temp = pick_temp();
        pace();
        offer_tick(keys, temp, valid, 1'b0, '0);
      end
      drain();
    end

    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d scan ticks (%0d with invalid temperature), checked %0d results",
             ticks_sent, ticks_skipped, results_checked);
    $display("over %0d register settings and %0d register writes; %0d mismatches",
             settings_run + 1, reg_writes, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
rtl/fmcd_pkg.sv
rtl/fmcd_cfg_regs.sv
rtl/fmcd_key_qual.sv
rtl/fmcd_ctrl.sv
rtl/fan_mode_controller_debounced_core.sv
tb/sv/fan_mode_controller_debounced_core_tb.sv
